[rtl/core/cusum_tp_pkg.sv]
// ----------------------------------------------------------------------------
// cusum_tp_pkg
// Shared types and constants of the CUSUM traffic predictor.
// ----------------------------------------------------------------------------
package cusum_tp_pkg;

  // field widths
  localparam int unsigned CH_IN_W   = 3;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned MEAN_W    = 23;
  localparam int unsigned PRED_W    = 16;
  localparam int unsigned RHO_W     = 7;
  localparam int unsigned THR_W     = 23;
  localparam int unsigned CFG_DW    = 23;
  localparam int unsigned CFG_IDX_W = 1;
  // wide enough to compare any channel code against a channel count up to 64
  localparam int unsigned CH_CMP_W  = 7;

  // arithmetic constants
  localparam logic [CNT_W-1:0]  COUNT_MAX  = 16'd65534;
  localparam logic [RHO_W-1:0]  SCALE      = 7'd100;
  localparam logic [RHO_W-1:0]  PRED_ROUND = 7'd99;

  // exact divide by 100 for dividends below 2**30: q = (x * RECIP_M) >> RECIP_SH
  localparam int unsigned DIVX_W   = 30;
  localparam int unsigned RECIP_W  = 31;
  localparam int unsigned PROD_W   = DIVX_W + RECIP_W;
  localparam int unsigned RECIP_SH = 37;
  localparam logic [RECIP_W-1:0] RECIP_M = 31'd1374389535;

  // reset values of the configuration registers
  localparam logic [THR_W-1:0] THR_RESET = 23'd200;
  localparam logic [RHO_W-1:0] RHO_RESET = 7'd80;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // operation codes
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO       = 1'b1;

  // classified item passed from front to back
  typedef struct packed {
    logic               func;
    logic [CH_IN_W-1:0] channel;
    logic               hit;
  } item_t;

  // per-channel predictor state
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] cusum;
    logic [PRED_W-1:0] pred;
  } entry_t;

  // back-end sequencer
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_CUSUM = 8'b0000_0100,
    S_BLEND = 8'b0000_1000,
    S_DIV1  = 8'b0001_0000,
    S_MEAN  = 8'b0010_0000,
    S_DIV2  = 8'b0100_0000,
    S_PRED  = 8'b1000_0000
  } state_t;

endpackage

[rtl/core/cusum_tp_front.sv]
// ----------------------------------------------------------------------------
// cusum_tp_front
// Accepts input items, checks the channel range and queues them for the back.
// ----------------------------------------------------------------------------
module cusum_tp_front #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [cusum_tp_pkg::CH_IN_W-1:0] in_channel,
  input  logic                            q_pop,
  output logic                            q_valid,
  output cusum_tp_pkg::item_t             q_item
);
  import cusum_tp_pkg::*;

  item_t             fifo_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;
  item_t             new_item;

  // classify: channels past the configured count touch no state
  always_comb begin
    new_item.func    = in_func;
    new_item.channel = in_channel;
    new_item.hit     = (CH_CMP_W'(in_channel) < CH_CMP_W'(NUM_CHANNELS));
  end

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/cusum_tp_back.sv]
// ----------------------------------------------------------------------------
// cusum_tp_back
// Per-channel state memory and the read-modify-write sequencer that counts
// packets and runs the CUSUM / EWMA update at slotframe close.
// ----------------------------------------------------------------------------
module cusum_tp_back #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [cusum_tp_pkg::THR_W-1:0]   thr,
  input  logic [cusum_tp_pkg::RHO_W-1:0]   rho,
  input  logic                             q_valid,
  input  cusum_tp_pkg::item_t              q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cusum_tp_pkg::CH_IN_W-1:0] out_channel_out,
  output logic [cusum_tp_pkg::PRED_W-1:0]  out_predicted_cells,
  output logic [cusum_tp_pkg::CNT_W-1:0]   out_packet_count
);
  import cusum_tp_pkg::*;

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // state memory, valid bits stand in for the zero reset
  entry_t                  mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  entry_t                  rd_r;
  logic                    rd_vld_r;

  state_t state_r, state_nxt;
  item_t  item_r;
  entry_t ent_r;

  // datapath registers
  logic [MEAN_W-1:0]   dt_r;
  logic [MEAN_W:0]     s_r;
  logic                alarm_r;
  logic [DIVX_W-1:0]   prod_a_r;
  logic [DIVX_W-1:0]   prod_b_r;
  logic [DIVX_W-1:0]   div_x_r;
  logic [PROD_W-1:0]   div_p_r;
  logic [MEAN_W-1:0]   mu_r;

  // output register
  logic                out_valid_r;
  logic [CH_IN_W-1:0]  out_ch_r;
  logic [PRED_W-1:0]   out_pred_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [CH_CMP_W-1:0] q_ch_ext;
  logic [CH_CMP_W-1:0] w_ch_ext;
  logic [CH_W-1:0]     rd_idx;
  logic [CH_W-1:0]     wr_idx;
  logic                mem_re;
  logic                mem_we;
  entry_t              mem_wdata;
  entry_t              cur;
  logic [CNT_W-1:0]    cnt_inc;
  logic [PRED_W-1:0]   floor_cells;
  logic [CNT_W:0]      adj;
  logic [MEAN_W:0]     dt_full;
  logic signed [MEAN_W+1:0] s_full;
  logic [MEAN_W:0]     s_clamp;
  logic [RHO_W-1:0]    rho_eff;
  logic [MEAN_W:0]     quot;
  logic [MEAN_W-1:0]   mu_new;
  logic                out_load;
  logic [PRED_W-1:0]   out_pred_nxt;
  logic [CNT_W-1:0]    out_cnt_nxt;

  assign q_ch_ext = CH_CMP_W'(q_item.channel);
  assign w_ch_ext = CH_CMP_W'(item_r.channel);
  assign rd_idx   = q_ch_ext[CH_W-1:0];
  assign wr_idx   = w_ch_ext[CH_W-1:0];

  // entry as read, zero when never written
  assign cur = rd_vld_r ? rd_r : '0;

  // packet count step, saturating
  assign cnt_inc = (cur.cnt < COUNT_MAX) ? cur.cnt + 1'b1 : cur.cnt;

  // adjusted count and scaled demand
  always_comb begin
    floor_cells = (cur.pred != '0) ? cur.pred : PRED_W'(1);
    adj         = (cur.cnt >= floor_cells) ? ({1'b0, cur.cnt} + 1'b1) : {1'b0, cur.cnt};
    dt_full     = (MEAN_W+1)'(adj) * (MEAN_W+1)'(SCALE);
  end

  // clamped CUSUM statistic
  always_comb begin
    s_full  = $signed({2'b00, ent_r.cusum}) + $signed({2'b00, dt_r})
            - $signed({2'b00, ent_r.mean});
    s_clamp = s_full[MEAN_W+1] ? '0 : s_full[MEAN_W:0];
  end

  assign rho_eff = (rho > SCALE) ? SCALE : rho;

  // quotient of the shared divide-by-100 unit
  assign quot   = div_p_r[RECIP_SH +: (MEAN_W+1)];
  assign mu_new = alarm_r ? dt_r : quot[MEAN_W-1:0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = cur;
    out_load     = 1'b0;
    out_pred_nxt = '0;
    out_cnt_nxt  = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          mem_re    = q_item.hit;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (item_r.hit && (item_r.func == FUNC_CLOSE)) begin
          state_nxt = S_CUSUM;
        end else begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (item_r.hit) begin
            mem_we        = 1'b1;
            mem_wdata     = cur;
            mem_wdata.cnt = cnt_inc;
            out_pred_nxt  = cur.pred;
            out_cnt_nxt   = cnt_inc;
          end
        end
      end
      S_CUSUM: state_nxt = S_BLEND;
      S_BLEND: state_nxt = S_DIV1;
      S_DIV1:  state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_DIV2;
      S_DIV2:  state_nxt = S_PRED;
      S_PRED: begin
        mem_we          = 1'b1;
        mem_wdata.cnt   = '0;
        mem_wdata.mean  = mu_r;
        mem_wdata.cusum = alarm_r ? '0 : s_r[MEAN_W-1:0];
        mem_wdata.pred  = quot[PRED_W-1:0];
        out_load        = 1'b1;
        out_pred_nxt    = quot[PRED_W-1:0];
        out_cnt_nxt     = '0;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_idx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem_r[rd_idx];
    end
  end

  // valid bits and registered valid of the read entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (q_pop) begin
        rd_vld_r <= q_item.hit && vld_r[rd_idx];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    div_p_r <= PROD_W'(div_x_r) * PROD_W'(RECIP_M);
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == S_LOAD) begin
      ent_r <= cur;
      dt_r  <= dt_full[MEAN_W-1:0];
    end
    if (state_r == S_CUSUM) begin
      s_r      <= s_clamp;
      alarm_r  <= (s_clamp > {1'b0, thr});
      prod_a_r <= DIVX_W'(rho_eff) * DIVX_W'(ent_r.mean);
      prod_b_r <= DIVX_W'(SCALE - rho_eff) * DIVX_W'(dt_r);
    end
    if (state_r == S_BLEND) begin
      div_x_r <= prod_a_r + prod_b_r;
    end
    if (state_r == S_MEAN) begin
      mu_r    <= mu_new;
      div_x_r <= DIVX_W'(mu_new) + DIVX_W'(PRED_ROUND);
    end
    if (out_load) begin
      out_ch_r   <= item_r.channel;
      out_pred_r <= out_pred_nxt;
      out_cnt_r  <= out_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel_out     = out_ch_r;
  assign out_predicted_cells = out_pred_r;
  assign out_packet_count    = out_cnt_r;

endmodule

[rtl/core/cusum_traffic_predictor.sv]
// ----------------------------------------------------------------------------
// cusum_traffic_predictor
// Per-channel traffic demand predictor with CUSUM change detection and EWMA.
// ----------------------------------------------------------------------------
// A front stage takes one item per cycle into a two-entry queue while that
// queue has room; a back sequencer then works on one item at a time. A packet
// count (func 0) or an item for a channel at or beyond NUM_CHANNELS has its
// result registered from the LOAD state; a slotframe close (func 1) goes on
// through CUSUM, BLEND, DIV1, MEAN, DIV2 and PRED, steps set by the
// read-modify-write of the channel state memory and the divide-by-100
// multiplier that the mean and the prediction share in turn. A new item
// leaves the queue only once the previous result has been transferred. State
// resets to zero through per-channel valid bits, with no clearing pass.
// Configuration writes are meant for idle.
module cusum_traffic_predictor #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cusum_tp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cusum_tp_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [cusum_tp_pkg::CH_IN_W-1:0]   in_channel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cusum_tp_pkg::CH_IN_W-1:0]   out_channel_out,
  output logic [cusum_tp_pkg::PRED_W-1:0]    out_predicted_cells,
  output logic [cusum_tp_pkg::CNT_W-1:0]     out_packet_count
);
  import cusum_tp_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [RHO_W-1:0] rho_r;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      rho_r <= RHO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        REG_RHO:       rho_r <= cfg_wdata[RHO_W-1:0];
        default: ;
      endcase
    end
  end

  // accept, classify and queue
  cusum_tp_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_channel (in_channel),
    .q_pop      (q_pop),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  // state update and result
  cusum_tp_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .thr                 (thr_r),
    .rho                 (rho_r),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_channel_out     (out_channel_out),
    .out_predicted_cells (out_predicted_cells),
    .out_packet_count    (out_packet_count)
  );

`ifndef NO_ASSERTIONS
  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a transferred result is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("back-to-back results from the sequencer");

  // channels past the configured count report zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (CH_CMP_W'(out_channel_out) >= CH_CMP_W'(NUM_CHANNELS))
    |-> (out_predicted_cells == '0) && (out_packet_count == '0))
    else $error("nonzero result for an unmapped channel");
`endif

endmodule
